// ===== hw/rtl/json_string_unescape_macros.svh =====
// Assertion macros shared by the JSON string unescape RTL.
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`else

`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/jsu_pkg.sv =====
// Types and constants for the JSON string unescape block.
package jsu_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned HEX_W  = 16;

    localparam logic [LEN_W-1:0] CAP_RESET = 16'hFFFF;

    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
    localparam logic [BYTE_W-1:0] CH_QMARK     = 8'h3F;
    localparam logic [HEX_W-1:0]  ASCII_MAX    = 16'h007F;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_BODY = 2'd1,
        MODE_ESC  = 2'd2,
        MODE_HEX  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_BUSY  = 2'd0,
        STAT_DONE  = 2'd1,
        STAT_ERROR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_NOOPEN = 3'd1,
        ERR_ESCAPE = 3'd2,
        ERR_HEX    = 3'd3,
        ERR_UNTERM = 3'd4,
        ERR_CAP    = 3'd5
    } t_err;

    typedef struct packed {
        t_mode             mode;
        logic [1:0]        hex_cnt;
        logic [HEX_W-1:0]  hex_val;
        logic [LEN_W-1:0]  byte_cnt;
    } t_scan_state;

    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        t_status           status;
        t_err              err;
        logic [LEN_W-1:0]  decoded_length;
    } t_result;

endpackage

// ===== hw/rtl/jsu_in_if.sv =====
// Input channel: one raw literal byte per item.
interface jsu_in_if;
    logic                         valid;
    logic                         ready;
    logic [jsu_pkg::BYTE_W-1:0]   in_byte;
    logic                         end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/jsu_out_if.sv =====
// Output channel: one decode result per item.
interface jsu_out_if;
    logic                         valid;
    logic                         ready;
    logic                         out_valid;
    logic [jsu_pkg::BYTE_W-1:0]   out_byte;
    logic [1:0]                   status;
    logic [2:0]                   error_code;
    logic [jsu_pkg::LEN_W-1:0]    decoded_length;

    modport source (output valid, output out_valid, output out_byte, output status,
                    output error_code, output decoded_length, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input status,
                    input error_code, input decoded_length, output ready);
endinterface

// ===== hw/rtl/jsu_cfg_if.sv =====
// Configuration write channel: capacity register data.
interface jsu_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [jsu_pkg::LEN_W-1:0]    capacity_bytes;

    modport source (output valid, output capacity_bytes, input ready);
    modport sink   (input valid, input capacity_bytes, output ready);
endinterface

// ===== hw/rtl/jsu_step.sv =====
// Decode step: next scan state and result for one literal byte.
module jsu_step (
    input  jsu_pkg::t_scan_state          i_state,
    input  logic [jsu_pkg::BYTE_W-1:0]    i_byte,
    input  logic                          i_eoi,
    input  logic [jsu_pkg::LEN_W-1:0]     i_capacity,
    output jsu_pkg::t_scan_state          o_state,
    output jsu_pkg::t_result              o_result
);
    import jsu_pkg::*;

    // Hex digit decode: {ok, nibble}.
    function automatic logic [4:0] hex_of(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Single-letter escape decode: {ok, byte}.
    function automatic logic [BYTE_W:0] esc_of(input logic [BYTE_W-1:0] c);
        logic [BYTE_W:0] r;
        case (c)
            CH_QUOTE:     r = {1'b1, CH_QUOTE};
            CH_BACKSLASH: r = {1'b1, CH_BACKSLASH};
            CH_SLASH:     r = {1'b1, CH_SLASH};
            8'h6E:        r = {1'b1, 8'h0A};
            8'h72:        r = {1'b1, 8'h0D};
            8'h74:        r = {1'b1, 8'h09};
            8'h62:        r = {1'b1, 8'h08};
            8'h66:        r = {1'b1, 8'h0C};
            default:      r = '0;
        endcase
        return r;
    endfunction

    logic              room;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic [4:0]        hex_d;
    logic [BYTE_W:0]   esc_d;
    logic [HEX_W-1:0]  hex_next;
    t_err              err;
    t_status           status;
    t_scan_state       n_state;

    assign room     = ({1'b0, i_state.byte_cnt} + 17'd1) <= {1'b0, i_capacity};
    assign hex_d    = hex_of(i_byte);
    assign esc_d    = esc_of(i_byte);
    assign hex_next = {i_state.hex_val[HEX_W-5:0], hex_d[3:0]};

    always_comb begin
        n_state   = i_state;
        emit      = 1'b0;
        emit_byte = '0;
        err       = ERR_NONE;
        status    = STAT_BUSY;
        o_result  = '0;

        case (i_state.mode)
            MODE_IDLE: begin
                if (i_byte != CH_QUOTE) begin
                    err = ERR_NOOPEN;
                end else begin
                    n_state.byte_cnt = '0;
                    n_state.mode     = MODE_BODY;
                    if (i_eoi) err = ERR_UNTERM;
                end
            end
            MODE_BODY: begin
                if (i_byte == CH_QUOTE) begin
                    if (!room) begin
                        err = ERR_CAP;
                    end else begin
                        status       = STAT_DONE;
                        n_state.mode = MODE_IDLE;
                    end
                end else if (i_byte == CH_BACKSLASH) begin
                    n_state.mode = MODE_ESC;
                    if (i_eoi) err = ERR_UNTERM;
                end else begin
                    emit      = 1'b1;
                    emit_byte = i_byte;
                end
            end
            MODE_ESC: begin
                if (i_byte == CH_U) begin
                    n_state.mode    = MODE_HEX;
                    n_state.hex_cnt = '0;
                    n_state.hex_val = '0;
                    if (i_eoi) err = ERR_UNTERM;
                end else if (!esc_d[BYTE_W]) begin
                    err = ERR_ESCAPE;
                end else begin
                    emit         = 1'b1;
                    emit_byte    = esc_d[BYTE_W-1:0];
                    n_state.mode = MODE_BODY;
                end
            end
            MODE_HEX: begin
                if (!hex_d[4]) begin
                    err = ERR_HEX;
                end else begin
                    n_state.hex_val = hex_next;
                    if (i_state.hex_cnt == 2'd3) begin
                        n_state.hex_cnt = '0;
                        n_state.mode    = MODE_BODY;
                        emit            = 1'b1;
                        emit_byte       = (hex_next <= ASCII_MAX) ? hex_next[BYTE_W-1:0]
                                                                  : CH_QMARK;
                    end else begin
                        n_state.hex_cnt = i_state.hex_cnt + 2'd1;
                        if (i_eoi) err = ERR_UNTERM;
                    end
                end
            end
            default: begin
                err = ERR_NOOPEN;
            end
        endcase

        // Deliver a decoded byte if the count with it stays within the capacity.
        if (err == ERR_NONE && emit) begin
            if (!room) begin
                err = ERR_CAP;
            end else begin
                n_state.byte_cnt   = i_state.byte_cnt + 16'd1;
                o_result.out_valid = 1'b1;
                o_result.out_byte  = emit_byte;
                if (i_eoi) err = ERR_UNTERM;
            end
        end

        // Any error drops the byte and returns to idle.
        if (err != ERR_NONE) begin
            status             = STAT_ERROR;
            o_result.out_valid = 1'b0;
            o_result.out_byte  = '0;
            n_state.mode       = MODE_IDLE;
            n_state.hex_cnt    = '0;
        end

        o_result.status         = status;
        o_result.err            = err;
        o_result.decoded_length = n_state.byte_cnt;
    end

    assign o_state = n_state;

endmodule

// ===== hw/rtl/json_string_unescape.sv =====
// Top level of the streaming JSON string literal unescape block.
//
// Usage:
//   i_in  carries one raw byte of a string literal per item, opening quote
//         first, with end_of_input set on the last byte available.
//   o_out carries exactly one result item per input item: a decoded byte
//         flag and value, status (busy, done, error), error code and the
//         decoded length so far.
//   i_cfg writes the capacity register (decoded bytes plus terminator).
//         It is always ready; write it only while no item is in flight.
// Latency: the result of an item is valid the cycle after it is accepted.
// Throughput: one item per cycle unless stalled; decode is a single pass of
//   small logic from the scan state and the byte into the result register.
// Stall: when the receiver holds off, the result register keeps its item
//   and i_in.ready drops until that item is taken; the same cycle that
//   takes it may accept the next input item.
// Reset: scan state returns to idle with counts cleared, capacity returns
//   to 65535 and the output register empties.
// After a finish or an error the next byte is taken as a new opening quote.
module json_string_unescape (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out,
    jsu_cfg_if.sink   i_cfg
);
    import jsu_pkg::*;

    `include "json_string_unescape_macros.svh"

    t_scan_state        r_state;
    t_scan_state        n_state;
    t_result            r_out;
    t_result            n_result;
    logic               r_out_vld;
    logic [LEN_W-1:0]   r_cap;
    logic               in_acc;

    // Take a new item whenever the result register is empty or being drained.
    assign i_in.ready  = !r_out_vld || o_out.ready;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    jsu_step u_step (
        .i_state    (r_state),
        .i_byte     (i_in.in_byte),
        .i_eoi      (i_in.end_of_input),
        .i_capacity (r_cap),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg.valid) begin
            r_cap <= i_cfg.capacity_bytes;
        end
    end

    // Scan state: advance only on an accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_IDLE, hex_cnt: '0, hex_val: '0, byte_cnt: '0};
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // Result register valid flag: fill on accept, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (in_acc) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Result payload: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_result;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.out_valid      = r_out.out_valid;
    assign o_out.out_byte       = r_out.out_byte;
    assign o_out.status         = r_out.status;
    assign o_out.error_code     = r_out.err;
    assign o_out.decoded_length = r_out.decoded_length;

    // An error result never carries a byte, and only errors carry a code.
    `JSU_ASSERT_NOW(a_err_no_byte, i_clk, i_rst_n,
        r_out_vld && r_out.status == STAT_ERROR,
        !r_out.out_valid && r_out.out_byte == '0 && r_out.err != ERR_NONE)
    `JSU_ASSERT_NOW(a_code_only_on_err, i_clk, i_rst_n,
        r_out_vld && r_out.status != STAT_ERROR, r_out.err == ERR_NONE)
    // A finished or failed literal leaves the scanner idle.
    `JSU_ASSERT_NOW(a_idle_after_end, i_clk, i_rst_n,
        r_out_vld && r_out.status != STAT_BUSY,
        r_state.mode == MODE_IDLE && r_state.hex_cnt == '0)
    // The reported length tracks the byte counter.
    `JSU_ASSERT_NOW(a_len_tracks, i_clk, i_rst_n,
        r_out_vld, r_out.decoded_length == r_state.byte_cnt)
    // Every accepted item yields a result in the next cycle.
    `JSU_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, in_acc, r_out_vld)

endmodule
